// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ibp_pkg.sv
// Package with the types and constants of the image border padding block.
`timescale 1ns / 1ps
package ibp_pkg;

   localparam int MOD_W = 10;
   localparam int MOD_CNT_W = 4;

   localparam logic [2:0] REG_IMG_WIDTH = 3'd0;
   localparam logic [2:0] REG_IMG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PAD_TOP = 3'd2;
   localparam logic [2:0] REG_PAD_BOTTOM = 3'd3;
   localparam logic [2:0] REG_PAD_LEFT = 3'd4;
   localparam logic [2:0] REG_PAD_RIGHT = 3'd5;
   localparam logic [2:0] REG_BORDER_MODE = 3'd6;
   localparam logic [2:0] REG_FILL_VALUE = 3'd7;

   localparam logic [2:0] MODE_REPLICATE = 3'd0;
   localparam logic [2:0] MODE_REFLECT = 3'd1;
   localparam logic [2:0] MODE_REFLECT101 = 3'd2;
   localparam logic [2:0] MODE_WRAP = 3'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_MAP   = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic       fill;
      logic [8:0] idx;
   } map_type;

endpackage

// File: rtl/ibp_mod.sv
// Restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module ibp_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ibp_pkg::MOD_W-1:0] dividend,
   input  logic [ibp_pkg::MOD_W-1:0] divisor,
   output logic [ibp_pkg::MOD_W-1:0] remainder,
   output logic                      busy
);
   import ibp_pkg::*;

   logic                 busy_ff;
   logic [MOD_CNT_W-1:0] cnt_ff;
   logic [MOD_W-1:0]     dvd_ff;
   logic [MOD_W-1:0]     dvs_ff;
   logic [MOD_W-1:0]     rem_ff;
   logic [MOD_W:0]       trial;
   logic [MOD_W-1:0]     rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[MOD_W-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = MOD_W'(trial - {1'b0, dvs_ff});
      end else begin
         rem_in = trial[MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= MOD_CNT_W'(MOD_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[MOD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign remainder = rem_ff;
   assign busy = busy_ff;

endmodule

// File: rtl/image_border_padding.sv
// Image border padding: a source image store read back through a padded coordinate map.
`timescale 1ns / 1ps
// Write beats store one sample of the source image; read beats name a coordinate of the padded
// image and return the sample it maps to under the selected border mode, or the fill byte of the
// channel in constant mode. The block works on one beat at a time. A write or an out-of-range
// beat goes from the check state straight to the done state. A read waits in the remainder state
// for the two remainder units (one per axis, running side by side), which retire one bit per
// cycle; the mapping stage and the registered read of the image memory follow them. Results wait
// in an output register, so the next beat is taken while a result is still unclaimed. The image
// memory needs no clearing after reset; reading a sample never written is undefined.
module image_border_padding #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNELS = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // row[9:0], col[19:10], channel[21:20], data_in[29:22]
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // sample_out
   output logic        rsp_tuser,  // error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import ibp_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [8:0]  img_width_ff;
   logic [8:0]  img_height_ff;
   logic [7:0]  pad_top_ff;
   logic [7:0]  pad_bottom_ff;
   logic [7:0]  pad_left_ff;
   logic [7:0]  pad_right_ff;
   logic [2:0]  border_mode_ff;
   logic [31:0] fill_value_ff;

   state_type state_ff, state_in;

   logic       opcode_ff;
   logic [9:0] row_ff;
   logic [9:0] col_ff;
   logic [1:0] ch_ff;
   logic [7:0] data_ff;

   logic [8:0] sr_ff;
   logic [8:0] sc_ff;
   logic       fill_ff;
   logic [7:0] res_sample_ff;
   logic       res_err_ff;
   logic       from_mem_ff;
   logic [7:0] rd_data_ff;

   logic       rsp_tvalid_ff;
   logic [7:0] rsp_sample_ff;
   logic       rsp_err_ff;

   logic [7:0] store_mem [DEPTH];

   logic [8:0]       w, h;
   logic [10:0]      ph, pw;
   logic             ch_bad, wr_err, rd_err;
   logic [11:0]      pr, pc;
   logic [MOD_W-1:0] abs_r, abs_c, m_r, m_c, rem_r, rem_c;
   logic             busy_r, busy_c, div_start;
   map_type          map_r, map_c;
   logic             mem_we, mem_re, out_free;
   logic [AW-1:0]    mem_addr;

   function automatic logic [MOD_W-1:0] mod_divisor(input logic [8:0] len,
                                                   input logic [2:0] mode);
      logic [MOD_W-1:0] len2;
      len2 = {len, 1'b0};
      case (mode)
         MODE_REFLECT: mod_divisor = len2;
         MODE_REFLECT101: mod_divisor = (len == 9'd1) ? {1'b0, len} : len2 - 10'd2;
         default: mod_divisor = {1'b0, len};
      endcase
   endfunction

   function automatic map_type map_axis(input logic [11:0] p, input logic [8:0] len,
                                        input logic [2:0] mode, input logic [MOD_W-1:0] r,
                                        input logic [MOD_W-1:0] m);
      logic             neg;
      logic [MOD_W-1:0] q;
      logic [MOD_W-1:0] len2;
      map_type          res;
      neg = p[11];
      q = (neg && r != '0) ? m - r : r;
      len2 = {len, 1'b0};
      res.fill = 1'b0;
      res.idx = '0;
      if (!neg && p[10:0] < {2'b00, len}) begin
         res.idx = p[8:0];
      end else begin
         case (mode)
            MODE_REPLICATE: res.idx = neg ? 9'd0 : len - 9'd1;
            MODE_REFLECT: begin
               if (len != 9'd1) begin
                  res.idx = (q >= {1'b0, len}) ? 9'(len2 - 10'd1 - q) : q[8:0];
               end
            end
            MODE_REFLECT101: begin
               if (len != 9'd1) begin
                  res.idx = (q >= {1'b0, len}) ? 9'(len2 - 10'd2 - q) : q[8:0];
               end
            end
            MODE_WRAP: res.idx = q[8:0];
            default: res.fill = 1'b1;
         endcase
      end
      map_axis = res;
   endfunction

   always_comb begin
      if (img_width_ff == '0) begin
         w = 9'd1;
      end else if (32'(img_width_ff) > MAX_WIDTH) begin
         w = 9'(MAX_WIDTH);
      end else begin
         w = img_width_ff;
      end
      if (img_height_ff == '0) begin
         h = 9'd1;
      end else if (32'(img_height_ff) > MAX_HEIGHT) begin
         h = 9'(MAX_HEIGHT);
      end else begin
         h = img_height_ff;
      end
   end

   assign ph = {3'b000, pad_top_ff} + {2'b00, h} + {3'b000, pad_bottom_ff};
   assign pw = {3'b000, pad_left_ff} + {2'b00, w} + {3'b000, pad_right_ff};
   assign ch_bad = 32'(ch_ff) >= CHANNELS;
   assign wr_err = ({1'b0, row_ff} >= {2'b00, h}) || ({1'b0, col_ff} >= {2'b00, w}) || ch_bad;
   assign rd_err = ({1'b0, row_ff} >= ph) || ({1'b0, col_ff} >= pw) || ch_bad;

   assign pr = {2'b00, row_ff} - {4'h0, pad_top_ff};
   assign pc = {2'b00, col_ff} - {4'h0, pad_left_ff};
   assign abs_r = pr[11] ? MOD_W'(-pr) : pr[MOD_W-1:0];
   assign abs_c = pc[11] ? MOD_W'(-pc) : pc[MOD_W-1:0];
   assign m_r = mod_divisor(h, border_mode_ff);
   assign m_c = mod_divisor(w, border_mode_ff);
   assign div_start = (state_ff == ST_CHECK) && (opcode_ff == OP_READ) && !rd_err;

   ibp_mod u_mod_row (
      .clock(clock), .reset(reset), .start(div_start), .dividend(abs_r), .divisor(m_r),
      .remainder(rem_r), .busy(busy_r)
   );

   ibp_mod u_mod_col (
      .clock(clock), .reset(reset), .start(div_start), .dividend(abs_c), .divisor(m_c),
      .remainder(rem_c), .busy(busy_c)
   );

   assign map_r = map_axis(pr, h, border_mode_ff, rem_r, m_r);
   assign map_c = map_axis(pc, w, border_mode_ff, rem_c, m_c);

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign mem_we = (state_ff == ST_CHECK) && (opcode_ff == OP_WRITE) && !wr_err;
   assign mem_re = (state_ff == ST_READ) && !fill_ff;

   always_comb begin
      if (state_ff == ST_READ) begin
         mem_addr = AW'((32'(sr_ff) * MAX_WIDTH + 32'(sc_ff)) * CHANNELS + 32'(ch_ff));
      end else begin
         mem_addr = AW'((32'(row_ff[8:0]) * MAX_WIDTH + 32'(col_ff[8:0])) * CHANNELS
                        + 32'(ch_ff));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: state_in = div_start ? ST_MOD : ST_DONE;
         ST_MOD: if (!busy_r && !busy_c) state_in = ST_MAP;
         ST_MAP: state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff <= 9'd1;
         img_height_ff <= 9'd1;
         pad_top_ff <= '0;
         pad_bottom_ff <= '0;
         pad_left_ff <= '0;
         pad_right_ff <= '0;
         border_mode_ff <= MODE_REPLICATE;
         fill_value_ff <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            REG_IMG_WIDTH: img_width_ff <= csr_wdata[8:0];
            REG_IMG_HEIGHT: img_height_ff <= csr_wdata[8:0];
            REG_PAD_TOP: pad_top_ff <= csr_wdata[7:0];
            REG_PAD_BOTTOM: pad_bottom_ff <= csr_wdata[7:0];
            REG_PAD_LEFT: pad_left_ff <= csr_wdata[7:0];
            REG_PAD_RIGHT: pad_right_ff <= csr_wdata[7:0];
            REG_BORDER_MODE: border_mode_ff <= csr_wdata[2:0];
            REG_FILL_VALUE: fill_value_ff <= csr_wdata;
            default: fill_value_ff <= fill_value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         opcode_ff <= req_tuser;
         row_ff <= req_tdata[9:0];
         col_ff <= req_tdata[19:10];
         ch_ff <= req_tdata[21:20];
         data_ff <= req_tdata[29:22];
      end
      if (state_ff == ST_CHECK) begin
         res_sample_ff <= '0;
         res_err_ff <= (opcode_ff == OP_WRITE) ? wr_err : rd_err;
         from_mem_ff <= 1'b0;
      end
      if (state_ff == ST_MAP) begin
         sr_ff <= map_r.idx;
         sc_ff <= map_c.idx;
         fill_ff <= map_r.fill || map_c.fill;
      end
      if (state_ff == ST_READ) begin
         res_sample_ff <= fill_value_ff[{ch_ff, 3'b000} +: 8];
         from_mem_ff <= !fill_ff;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_sample_ff <= from_mem_ff ? rd_data_ff : res_sample_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= data_ff;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_sample_ff;
   assign rsp_tuser = rsp_err_ff;

endmodule

// File: rtl/ibp_checker.sv
// Port-level checker for the image border padding block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ibp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser
);

   `ASSERT_ALWAYS(a_reset_clears_rsp, reset, !rsp_tvalid, "result valid after reset")
   `ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "second beat taken early")
   `ASSERT_SAME(a_error_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 8'd0, "error with nonzero data")
   `ASSERT_NEXT(a_rsp_held, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "stalled data moved")

endmodule

bind image_border_padding ibp_checker u_ibp_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
